FILE: rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg : shared types and constants
// sizes, operation codes, wavefront beat type and controller states
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int MAX_LEN = 32;
    localparam int ROW_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int FILL_W  = $clog2(2 * MAX_LEN + 1);
    localparam int LEN_W   = 6;

    localparam logic [1:0] OP_APPEND_A = 2'd0;
    localparam logic [1:0] OP_APPEND_B = 2'd1;
    localparam logic [1:0] OP_COMPUTE  = 2'd2;

    // one row of the score table travelling along the chain
    typedef struct packed {
        logic             valid;
        logic [7:0]       sym;
        logic [ROW_W-1:0] row;
        logic [CNT_W-1:0] left;
        logic [CNT_W-1:0] diag;
    } t_wave;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FILL,
        ST_TRACE,
        ST_EMIT
    } t_state;

endpackage

FILE: rtl/lcs_cell.sv
// ----------------------------------------------------------------------------
// lcs_cell : one column of the score table
// holds one second-string symbol, the running column score and one
// direction bit per row for the traceback
// ----------------------------------------------------------------------------
module lcs_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lcs_pkg::t_wave            i_wave,
    input  logic                      i_clear,
    input  logic                      i_load,
    input  logic [7:0]                i_load_sym,
    input  logic [lcs_pkg::ROW_W-1:0] i_rd_row,
    output lcs_pkg::t_wave            o_wave,
    output logic [lcs_pkg::CNT_W-1:0] o_score,
    output logic [7:0]                o_sym,
    output logic                      o_dir
);
    import lcs_pkg::*;

    t_wave              r_wave;
    logic [CNT_W-1:0]   r_score;
    logic [7:0]         r_sym;
    logic [MAX_LEN-1:0] r_dir;

    logic               n_left_ge;
    logic [CNT_W-1:0]   n_score;

    always_comb begin
        n_left_ge = (i_wave.left >= r_score);
        if (i_wave.sym == r_sym) begin
            n_score = i_wave.diag + CNT_W'(1);
        end else if (n_left_ge) begin
            n_score = i_wave.left;
        end else begin
            n_score = r_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= '0;
        end else begin
            r_wave.valid <= i_wave.valid;
            r_wave.sym   <= i_wave.sym;
            r_wave.row   <= i_wave.row;
            r_wave.left  <= n_score;
            r_wave.diag  <= r_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_score <= '0;
        end else if (i_wave.valid) begin
            r_score          <= n_score;
            r_dir[i_wave.row] <= n_left_ge;
        end
        if (i_load) begin
            r_sym <= i_load_sym;
        end
    end

    assign o_wave  = r_wave;
    assign o_score = r_score;
    assign o_sym   = r_sym;
    assign o_dir   = r_dir[i_rd_row];

endmodule

FILE: rtl/longest_common_subsequence_core.sv
// ----------------------------------------------------------------------------
// longest_common_subsequence_core : lcs of two byte strings
// systolic score fill over a chain of column cells, then traceback
// ----------------------------------------------------------------------------
// channel  dir  tdata                                tuser          tlast
// s_axis   in   [7:0] symbol                         [1:0] operation -
// m_axis   out  [5:0] length [13:6] symbol [14] trunc [0] sym valid  last
//
// a compute clears the cells, fills the score table as the row wave crosses
// the cell chain, walks the traceback, then sends one beat per symbol (a
// single empty beat for length zero) at the output pace
// the input is not ready from compute until the last result beat is taken
// reset clears counts, flag and control; strings and score bits need none
// ----------------------------------------------------------------------------
module longest_common_subsequence_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // symbol
    input  logic [1:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // length, symbol, truncated, pad
    output logic        m_axis_tuser,   // symbol_valid
    output logic        m_axis_tlast    // last
);
    import lcs_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_n1, r_n2;       // load counts
    logic [CNT_W-1:0] r_cn1, r_cn2;     // counts latched at compute
    logic             r_ovf, r_trunc;
    logic [FILL_W-1:0] r_fill;
    logic [CNT_W-1:0] r_len, r_pos, r_r, r_c;
    logic [ROW_W-1:0] r_k;
    logic [7:0]       r_a  [MAX_LEN];
    logic [7:0]       r_tb [MAX_LEN];

    logic             in_beat, out_beat, out_last;
    logic [FILL_W-1:0] fill_end;
    logic             fill_done, trace_done;
    logic [ROW_W-1:0] rm1, cm1, rd_row;
    logic [CNT_W-1:0] len_calc;
    logic             step_match;

    t_wave            w      [MAX_LEN+1];
    logic [CNT_W-1:0] c_score[MAX_LEN];
    logic [7:0]       c_sym  [MAX_LEN];
    logic             c_dir  [MAX_LEN];

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    // traceback indices, one below the 1-based table coordinates
    assign rm1 = ROW_W'(r_r - CNT_W'(1));
    assign cm1 = ROW_W'(r_c - CNT_W'(1));
    assign rd_row = rm1;

    assign fill_end   = FILL_W'(r_cn1) + FILL_W'(MAX_LEN);
    assign fill_done  = (r_fill == fill_end);
    assign trace_done = (r_r == '0) || (r_c == '0);
    assign len_calc   = (r_cn2 == '0) ? '0 : c_score[ROW_W'(r_cn2 - CNT_W'(1))];
    assign step_match = (r_a[rm1] == c_sym[cm1]);
    assign out_last   = (r_len == '0) || (CNT_W'(r_k) + CNT_W'(1) == r_len);

    // row feeder into the head of the chain
    always_comb begin
        w[0]       = '0;
        w[0].valid = (r_state == ST_FILL) && (r_fill < FILL_W'(r_cn1));
        w[0].row   = ROW_W'(r_fill);
        w[0].sym   = r_a[ROW_W'(r_fill)];
    end

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        lcs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wave     (w[g]),
            .i_clear    (r_state == ST_CLEAR),
            .i_load     (in_beat && (s_axis_tuser == OP_APPEND_B) &&
                         (r_n2 == CNT_W'(g))),
            .i_load_sym (s_axis_tdata),
            .i_rd_row   (rd_row),
            .o_wave     (w[g+1]),
            .o_score    (c_score[g]),
            .o_sym      (c_sym[g]),
            .o_dir      (c_dir[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_beat && (s_axis_tuser == OP_COMPUTE)) n_state = ST_CLEAR;
            end
            ST_CLEAR: n_state = ST_FILL;
            ST_FILL: begin
                if (fill_done) n_state = ST_TRACE;
            end
            ST_TRACE: begin
                if (trace_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_beat && out_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        m_axis_tvalid = (r_state == ST_EMIT);
        m_axis_tuser  = (r_len != '0);
        m_axis_tlast  = out_last;
        m_axis_tdata  = {1'b0, r_trunc,
                         (r_len == '0) ? 8'd0 : r_tb[r_k],
                         LEN_W'(r_len)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n1    <= '0;
            r_n2    <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_beat) begin
                case (s_axis_tuser)
                    OP_APPEND_A: begin
                        if (r_n1 < CNT_W'(MAX_LEN)) r_n1 <= r_n1 + CNT_W'(1);
                        else                        r_ovf <= 1'b1;
                    end
                    OP_APPEND_B: begin
                        if (r_n2 < CNT_W'(MAX_LEN)) r_n2 <= r_n2 + CNT_W'(1);
                        else                        r_ovf <= 1'b1;
                    end
                    OP_COMPUTE: begin
                        r_n1  <= '0;
                        r_n2  <= '0;
                        r_ovf <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath: string store, fill counter, traceback walk, emit index
    always_ff @(posedge i_clk) begin
        if (in_beat && (s_axis_tuser == OP_APPEND_A) && (r_n1 < CNT_W'(MAX_LEN))) begin
            r_a[ROW_W'(r_n1)] <= s_axis_tdata;
        end
        if (in_beat && (s_axis_tuser == OP_COMPUTE)) begin
            r_cn1   <= r_n1;
            r_cn2   <= r_n2;
            r_trunc <= r_ovf;
        end
        if (r_state == ST_CLEAR) begin
            r_fill <= '0;
        end else if (r_state == ST_FILL) begin
            r_fill <= r_fill + FILL_W'(1);
            if (fill_done) begin
                r_len <= len_calc;
                r_pos <= len_calc;
                r_r   <= r_cn1;
                r_c   <= r_cn2;
            end
        end
        if ((r_state == ST_TRACE) && !trace_done) begin
            if (step_match) begin
                if (r_pos != '0) begin
                    r_pos <= r_pos - CNT_W'(1);
                    r_tb[ROW_W'(r_pos - CNT_W'(1))] <= r_a[rm1];
                end
                r_r <= r_r - CNT_W'(1);
                r_c <= r_c - CNT_W'(1);
            end else if (c_dir[cm1]) begin
                // left score at least the upper one
                r_c <= r_c - CNT_W'(1);
            end else begin
                r_r <= r_r - CNT_W'(1);
            end
        end
        if (r_state == ST_TRACE) begin
            r_k <= '0;
        end else if (out_beat && !out_last) begin
            r_k <= r_k + ROW_W'(1);
        end
    end

    // checks
    a_busy_when_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while results pending");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("empty result not marked last");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && m_axis_tlast) |=> s_axis_tready)
        else $error("not idle after last beat");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (s_axis_tuser == OP_COMPUTE)) |=> !s_axis_tready)
        else $error("input ready during compute");

endmodule

FILE: dv/tb_longest_common_subsequence_core.sv
// ----------------------------------------------------------------------------
// tb_longest_common_subsequence_core : self-checking bench for the lcs core
// drives append and compute beats, predicts every result beat from its own
// score table and traceback, and compares each output beat field by field
// ----------------------------------------------------------------------------
module tb_longest_common_subsequence_core;
    import lcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [5:0] length;
        logic [7:0] sym;
        logic       sym_valid;
        logic       trunc;
        logic       last;
    } t_lcs_beat;

    // directed rows: op, symbol, and for fixed rows an expected last beat
    typedef struct {
        logic [1:0] op;
        logic [7:0] sym;
        bit         fixed;
        t_lcs_beat  exp_beat;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    longest_common_subsequence_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor state
    logic [7:0] str_a [MAX_LEN];
    logic [7:0] str_b [MAX_LEN];
    int         cnt_a, cnt_b;
    bit         dropped;
    t_lcs_beat  lcs_queue [$];
    t_lcs_beat  fixed_queue [$];

    int  n_fail;
    int  n_beats_out;
    int  n_computes;
    int  idle_cycles;
    bit  calm;          // no idling on either side while set
    bit  finished;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // model of one accepted input beat
    task automatic predict_lcs(input logic [1:0] op, input logic [7:0] sym);
        int score [MAX_LEN+1][MAX_LEN+1];
        logic [7:0] trace [MAX_LEN];
        int r, c, len, pos;
        t_lcs_beat b;
        if (op == OP_APPEND_A) begin
            if (cnt_a < MAX_LEN) begin
                str_a[cnt_a] = sym;
                cnt_a++;
            end else dropped = 1'b1;
        end else if (op == OP_APPEND_B) begin
            if (cnt_b < MAX_LEN) begin
                str_b[cnt_b] = sym;
                cnt_b++;
            end else dropped = 1'b1;
        end else if (op == OP_COMPUTE) begin
            for (r = 0; r <= cnt_a; r++) begin
                for (c = 0; c <= cnt_b; c++) begin
                    if (r == 0 || c == 0) score[r][c] = 0;
                    else if (str_a[r-1] == str_b[c-1]) score[r][c] = score[r-1][c-1] + 1;
                    else score[r][c] = (score[r-1][c] > score[r][c-1]) ?
                                       score[r-1][c] : score[r][c-1];
                end
            end
            len = score[cnt_a][cnt_b];
            pos = len;
            r = cnt_a;
            c = cnt_b;
            while (r > 0 && c > 0) begin
                if (str_a[r-1] == str_b[c-1]) begin
                    if (pos > 0) begin
                        pos--;
                        trace[pos] = str_a[r-1];
                    end
                    r--;
                    c--;
                end else if (score[r][c-1] >= score[r-1][c]) c--;
                else r--;
            end
            if (len == 0) begin
                b = '{6'd0, 8'd0, 1'b0, dropped, 1'b1};
                lcs_queue.push_back(b);
            end else begin
                for (int k = 0; k < len; k++) begin
                    b = '{len[5:0], trace[k], 1'b1, dropped, (k + 1 == len)};
                    lcs_queue.push_back(b);
                end
            end
            cnt_a = 0;
            cnt_b = 0;
            dropped = 1'b0;
            n_computes++;
        end
        // operation code 3 is ignored
    endtask

    // send one beat, idling at random before it; model it on acceptance
    task automatic send_beat(input logic [1:0] op, input logic [7:0] sym);
        if (!calm) begin
            while ($urandom_range(99) < 28) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= sym;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_lcs(op, sym);
    endtask

    // receiver: random stalls, compare each taken beat with the oldest prediction
    always @(posedge i_clk) begin
        t_lcs_beat got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[5:0], m_axis_tdata[13:6], m_axis_tuser,
                        m_axis_tdata[14], m_axis_tlast};
                n_beats_out++;
                if (lcs_queue.size() == 0) begin
                    $display("%0t: unexpected result beat, actual %p", $realtime, got);
                    n_fail++;
                end else begin
                    want = lcs_queue.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected %p actual %p",
                                 $realtime, want, got);
                        n_fail++;
                    end
                    // typed-in expectations for rows read off at a glance
                    if (fixed_queue.size() > 0 && want.last) begin
                        if (fixed_queue[0] !== got) begin
                            $display("%0t: fixed row mismatch, expected %p actual %p",
                                     $realtime, fixed_queue[0], got);
                            n_fail++;
                        end
                        void'(fixed_queue.pop_front());
                    end
                end
            end
            m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 28);
        end
    end

    // watchdog on cycles with no accepted beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !finished) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic wait_drained();
        while (lcs_queue.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_row rows [$];
        int   n_items;
        int   la, lb;
        logic [7:0] alpha;
        rows = {};
        n_fail = 0; n_beats_out = 0; n_computes = 0;
        cnt_a = 0; cnt_b = 0; dropped = 1'b0;
        calm = 1'b0; finished = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty compute after reset
        rows.push_back(t_row'{OP_COMPUTE, 8'h00, 1'b1, '{6'd0, 8'd0, 1'b0, 1'b0, 1'b1}});
        // single equal extreme symbols, zero symbol is ordinary
        rows.push_back(t_row'{OP_APPEND_A, 8'hFF, 1'b0, '0});
        rows.push_back(t_row'{OP_APPEND_B, 8'hFF, 1'b0, '0});
        rows.push_back(t_row'{OP_COMPUTE, 8'hA5, 1'b1, '{6'd1, 8'hFF, 1'b1, 1'b0, 1'b1}});
        rows.push_back(t_row'{OP_APPEND_A, 8'h00, 1'b0, '0});
        rows.push_back(t_row'{OP_APPEND_B, 8'h00, 1'b0, '0});
        rows.push_back(t_row'{2'd3, 8'h55, 1'b0, '0});          // ignored op
        rows.push_back(t_row'{OP_COMPUTE, 8'h00, 1'b1, '{6'd1, 8'h00, 1'b1, 1'b0, 1'b1}});
        // no common symbol
        rows.push_back(t_row'{OP_APPEND_A, 8'h01, 1'b0, '0});
        rows.push_back(t_row'{OP_APPEND_A, 8'h02, 1'b0, '0});
        rows.push_back(t_row'{OP_APPEND_B, 8'h03, 1'b0, '0});
        rows.push_back(t_row'{OP_COMPUTE, 8'h00, 1'b1, '{6'd0, 8'd0, 1'b0, 1'b0, 1'b1}});
        // one string empty
        rows.push_back(t_row'{OP_APPEND_B, 8'h7E, 1'b0, '0});
        rows.push_back(t_row'{OP_COMPUTE, 8'h00, 1'b1, '{6'd0, 8'd0, 1'b0, 1'b0, 1'b1}});
        // tie-breaking in the traceback: ab against ba
        rows.push_back(t_row'{OP_APPEND_A, 8'h61, 1'b0, '0});
        rows.push_back(t_row'{OP_APPEND_A, 8'h62, 1'b0, '0});
        rows.push_back(t_row'{OP_APPEND_B, 8'h62, 1'b0, '0});
        rows.push_back(t_row'{OP_APPEND_B, 8'h61, 1'b0, '0});
        rows.push_back(t_row'{OP_COMPUTE, 8'h00, 1'b0, '0});
        foreach (rows[i]) begin
            if (rows[i].fixed) fixed_queue.push_back(rows[i].exp_beat);
            send_beat(rows[i].op, rows[i].sym);
        end
        // full strings of equal symbols plus overflow on both sides
        for (int i = 0; i < MAX_LEN + 2; i++) send_beat(OP_APPEND_A, 8'hC3);
        for (int i = 0; i < MAX_LEN + 1; i++) send_beat(OP_APPEND_B, 8'hC3);
        send_beat(OP_COMPUTE, 8'h00);
        s_axis_tvalid <= 1'b0;

        // pause until every expected result has come
        wait_drained();

        // random runs: mostly small strings over small alphabets
        n_items = 0;
        while (n_items < 310) begin
            calm = (n_items >= 150 && n_items < 210);
            la = ($urandom_range(9) == 0) ? $urandom_range(MAX_LEN + 3) : $urandom_range(8);
            lb = ($urandom_range(9) == 0) ? $urandom_range(MAX_LEN + 3) : $urandom_range(8);
            alpha = ($urandom_range(3) == 0) ? 8'hFF : 8'h03;
            for (int i = 0; i < la + lb; i++) begin
                if ($urandom_range(19) == 0) send_beat(2'd3, 8'($urandom_range(255)));
                else if ($urandom_range(la + lb - 1) < la)
                    send_beat(OP_APPEND_A, 8'($urandom_range(255)) & alpha);
                else send_beat(OP_APPEND_B, 8'($urandom_range(255)) & alpha);
                n_items++;
            end
            send_beat(OP_COMPUTE, 8'($urandom_range(255)));
            n_items++;
        end
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (200) @(posedge i_clk);
        finished = 1'b1;
        $display("covered %0d computes and %0d result beats, incl. empty, overflow and full strings",
                 n_computes, n_beats_out);
        if (n_fail == 0 && lcs_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lcs_pkg.sv
rtl/lcs_cell.sv
rtl/longest_common_subsequence_core.sv
dv/tb_longest_common_subsequence_core.sv
